// ----- rtl/imufd_pkg.sv -----
// Shared types and constants for the IMU serial frame decoder.
package imufd_pkg;

  localparam int unsigned FRAME_LEN  = 11;
  localparam int unsigned CNT_W      = $clog2(FRAME_LEN);
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned AXIS_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Position of the checksum byte within a frame.
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] KIND_POS = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_ACCEL    = 3'd0,
    ST_GYRO     = 3'd1,
    ST_ANGLE    = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_CSUM_ERR = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE  = 3'd0,
    REG_ACCEL_ID    = 3'd1,
    REG_GYRO_ID     = 3'd2,
    REG_ANGLE_ID    = 3'd3,
    REG_ACCEL_SCALE = 3'd4,
    REG_GYRO_SCALE  = 3'd5,
    REG_ANGLE_SCALE = 3'd6
  } reg_idx_e;

  localparam logic [7:0]  RST_START_BYTE  = 8'd85;
  localparam logic [7:0]  RST_ACCEL_ID    = 8'd81;
  localparam logic [7:0]  RST_GYRO_ID     = 8'd82;
  localparam logic [7:0]  RST_ANGLE_ID    = 8'd83;
  localparam logic [15:0] RST_ACCEL_SCALE = 16'd1568;
  localparam logic [15:0] RST_GYRO_SCALE  = 16'd20000;
  localparam logic [15:0] RST_ANGLE_SCALE = 16'd1800;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  accel_id;
    logic [7:0]  gyro_id;
    logic [7:0]  angle_id;
    logic [15:0] accel_scale;
    logic [15:0] gyro_scale;
    logic [15:0] angle_scale;
  } cfg_t;

endpackage

// ----- rtl/imufd_cfg_regs.sv -----
// Configuration register file of the IMU serial frame decoder.
module imufd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [imufd_pkg::CFG_IDX_W-1:0]      wr_index_i,
  input  logic [imufd_pkg::CFG_DATA_W-1:0]     wr_data_i,
  output imufd_pkg::cfg_t                      cfg_o
);

  imufd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        imufd_pkg::REG_START_BYTE:  cfg_d.start_byte  = wr_data_i[7:0];
        imufd_pkg::REG_ACCEL_ID:    cfg_d.accel_id    = wr_data_i[7:0];
        imufd_pkg::REG_GYRO_ID:     cfg_d.gyro_id     = wr_data_i[7:0];
        imufd_pkg::REG_ANGLE_ID:    cfg_d.angle_id    = wr_data_i[7:0];
        imufd_pkg::REG_ACCEL_SCALE: cfg_d.accel_scale = wr_data_i;
        imufd_pkg::REG_GYRO_SCALE:  cfg_d.gyro_scale  = wr_data_i;
        imufd_pkg::REG_ANGLE_SCALE: cfg_d.angle_scale = wr_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= imufd_pkg::RST_START_BYTE;
      cfg_q.accel_id    <= imufd_pkg::RST_ACCEL_ID;
      cfg_q.gyro_id     <= imufd_pkg::RST_GYRO_ID;
      cfg_q.angle_id    <= imufd_pkg::RST_ANGLE_ID;
      cfg_q.accel_scale <= imufd_pkg::RST_ACCEL_SCALE;
      cfg_q.gyro_scale  <= imufd_pkg::RST_GYRO_SCALE;
      cfg_q.angle_scale <= imufd_pkg::RST_ANGLE_SCALE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/imu_serial_frame_decoder_unit.sv -----
// Top level of the IMU serial frame decoder: byte input, frame parser, scaled result output.
//
// The decoder takes one received byte per word on the slave stream and returns one result
// word per complete 11-byte frame on the master stream. Bytes are dropped until one equals
// the start byte; the frame that follows is taken without resync. A byte is held in the
// input register, then processed; a frame's result enters the result register when its
// checksum byte is processed. The sustained rate is one byte per cycle unless the result
// stream stalls, set by the single frame-parsing stage; each 16-bit word is multiplied by
// the selected full-scale value as soon as its high byte arrives, on one shared 17x17
// multiplier, so the checksum byte only compares and selects. The kind and scale are latched
// on the kind byte, so configuration must stay still while a frame is in progress. Physical
// value = axis / 327680. Status 3 (unknown kind) and 4 (checksum error) come with zero axes.
module imu_serial_frame_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Received bytes. tdata: [7:0] rx_byte.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,
  // Results. tdata: [31:0] axis_x, [63:32] axis_y, [95:64] axis_z.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [95:0]                         m_axis_tdata,
  // tuser: [2:0] status.
  output logic [2:0]                          m_axis_tuser,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imufd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [imufd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CW = imufd_pkg::CNT_W;

  imufd_pkg::cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  imufd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;

  // Parser state.
  logic                in_frame_q, in_frame_d;
  logic [CW-1:0]       count_q, count_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          lo_byte_q, lo_byte_d;
  imufd_pkg::status_e  kind_q, kind_d;
  logic [15:0]         scale_q, scale_d;
  logic signed [imufd_pkg::AXIS_W-1:0] axis_q [imufd_pkg::NUM_AXES];
  logic signed [imufd_pkg::AXIS_W-1:0] axis_d [imufd_pkg::NUM_AXES];

  // Result register.
  logic                m_valid_q, m_valid_d;
  imufd_pkg::status_e  m_status_q, m_status_d;
  logic signed [imufd_pkg::AXIS_W-1:0] m_axis_q [imufd_pkg::NUM_AXES];
  logic signed [imufd_pkg::AXIS_W-1:0] m_axis_d [imufd_pkg::NUM_AXES];

  logic                en;
  logic                take;
  logic signed [16:0]  raw_word;
  logic signed [16:0]  scale_s;
  logic signed [33:0]  product;
  logic [1:0]          axis_idx;
  logic                is_word_hi;
  logic                csum_ok;
  logic                emit;

  // The parse stage advances whenever the result register is free or being drained.
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en || !in_valid_q;
  assign take          = en && in_valid_q;

  assign raw_word = $signed({in_byte_q[7], in_byte_q, lo_byte_q});
  assign scale_s  = $signed({1'b0, scale_q});
  assign product  = raw_word * scale_s;
  // Word high bytes sit at positions 3, 5 and 7.
  assign axis_idx   = count_q[2:1] - 2'd1;
  assign is_word_hi = count_q[0] && (count_q >= CW'(3)) && (count_q <= CW'(7));
  assign csum_ok    = (sum_q == in_byte_q);
  assign emit       = take && in_frame_q && (count_q == imufd_pkg::LAST_POS);

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_byte_d  = s_axis_tdata;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    sum_d      = sum_q;
    lo_byte_d  = lo_byte_q;
    kind_d     = kind_q;
    scale_d    = scale_q;
    axis_d     = axis_q;
    if (take) begin
      if (!in_frame_q) begin
        if (in_byte_q == cfg.start_byte) begin
          in_frame_d = 1'b1;
          count_d    = CW'(1);
          sum_d      = in_byte_q;
        end
      end else if (count_q != imufd_pkg::LAST_POS) begin
        count_d   = count_q + CW'(1);
        sum_d     = sum_q + in_byte_q;
        lo_byte_d = in_byte_q;
        if (count_q == imufd_pkg::KIND_POS) begin
          // The first matching id wins when ids coincide.
          priority if (in_byte_q == cfg.accel_id) begin
            kind_d  = imufd_pkg::ST_ACCEL;
            scale_d = cfg.accel_scale;
          end else if (in_byte_q == cfg.gyro_id) begin
            kind_d  = imufd_pkg::ST_GYRO;
            scale_d = cfg.gyro_scale;
          end else if (in_byte_q == cfg.angle_id) begin
            kind_d  = imufd_pkg::ST_ANGLE;
            scale_d = cfg.angle_scale;
          end else begin
            kind_d  = imufd_pkg::ST_UNKNOWN;
            scale_d = '0;
          end
        end
        if (is_word_hi) begin
          axis_d[axis_idx] = product[imufd_pkg::AXIS_W-1:0];
        end
      end else begin
        in_frame_d = 1'b0;
        count_d    = '0;
        sum_d      = '0;
      end
    end
  end

  always_comb begin
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_axis_d   = m_axis_q;
    if (en) begin
      m_valid_d = emit;
      if (emit) begin
        m_status_d = csum_ok ? kind_q : imufd_pkg::ST_CSUM_ERR;
        for (int i = 0; i < imufd_pkg::NUM_AXES; i++) begin
          m_axis_d[i] = (csum_ok && (kind_q != imufd_pkg::ST_UNKNOWN)) ? axis_q[i] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_frame_q <= 1'b0;
      count_q    <= '0;
      sum_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    lo_byte_q  <= lo_byte_d;
    kind_q     <= kind_d;
    scale_q    <= scale_d;
    axis_q     <= axis_d;
    m_status_q <= m_status_d;
    m_axis_q   <= m_axis_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {m_axis_q[2], m_axis_q[1], m_axis_q[0]};

  // A completed frame always lands in the result register on the next edge.
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_valid_q)
    else $error("frame end did not produce a result");

  // Error and unknown-kind results never carry axis data.
  a_zero_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && ((m_status_q == imufd_pkg::ST_UNKNOWN) ||
                   (m_status_q == imufd_pkg::ST_CSUM_ERR)))
    |-> (m_axis_tdata == '0))
    else $error("nonzero axes on a status-only result");

  // The byte counter stays at zero while hunting and inside the frame while framing.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_frame_q ? (count_q <= imufd_pkg::LAST_POS && count_q != '0) : (count_q == '0)))
    else $error("byte counter out of range");

  // The input side only stalls when a byte is already held.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && !en))
    else $error("input stalled without a held byte");

endmodule

// ----- dv/tb_imu_serial_frame_decoder_unit.sv -----
// Self-checking testbench for the IMU serial frame decoder: byte stream in, scaled frame results out.
module tb_imu_serial_frame_decoder_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_BYTES = 310;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 4;
  localparam int SUM_LEN = imufd_pkg::FRAME_LEN - 1;
  // Index past the last register; a write there must change nothing.
  localparam logic [imufd_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    imufd_pkg::status_e status;
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        z;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [95:0]                      m_axis_tdata;
  logic [2:0]                       m_axis_tuser;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [imufd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [imufd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  imu_serial_frame_decoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Decoder state mirrored from the bytes the block has taken.
  imufd_pkg::cfg_t cur_cfg = '{imufd_pkg::RST_START_BYTE, imufd_pkg::RST_ACCEL_ID,
                               imufd_pkg::RST_GYRO_ID, imufd_pkg::RST_ANGLE_ID,
                               imufd_pkg::RST_ACCEL_SCALE, imufd_pkg::RST_GYRO_SCALE,
                               imufd_pkg::RST_ANGLE_SCALE};
  bit         in_frame = 1'b0;
  int         byte_cnt = 0;
  logic [7:0] run_sum = '0;
  logic [7:0] frame_buf [SUM_LEN];

  frame_result_t decoded_q[$];
  logic [7:0]    rx_bytes_q[$];

  int n_pushed = 0;
  int n_taken = 0;
  int phase_bytes = 0;
  int n_settings = 1;
  int n_errors = 0;
  int cycle_cnt = 0;
  int status_seen [5] = '{default: 0};

  bit s_fire = 1'b0;
  bit m_fire = 1'b0;
  bit s_burst = 1'b0;
  bit m_burst = 1'b0;
  int s_gap = 0;
  int m_stall = 0;

  // Waits come in random lengths, with runs of back-to-back words in between.
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] scale_word(input logic [15:0] raw, input logic [15:0] scale);
    longint prod;
    prod = longint'($signed(raw)) * longint'(scale);
    return prod[31:0];
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    frame_result_t res;
    logic [15:0]   scale;
    if (!in_frame) begin
      if (b == cur_cfg.start_byte) begin
        frame_buf[0] = b;
        run_sum = b;
        byte_cnt = 1;
        in_frame = 1'b1;
      end
      return;
    end
    if (byte_cnt < SUM_LEN) begin
      frame_buf[byte_cnt] = b;
      run_sum = run_sum + b;
      byte_cnt++;
      return;
    end
    res.status = imufd_pkg::ST_CSUM_ERR;
    res.x = '0;
    res.y = '0;
    res.z = '0;
    if (run_sum == b) begin
      res.status = imufd_pkg::ST_UNKNOWN;
      scale = '0;
      // The first matching id wins when ids collide.
      if (frame_buf[1] == cur_cfg.accel_id) begin
        res.status = imufd_pkg::ST_ACCEL;
        scale = cur_cfg.accel_scale;
      end else if (frame_buf[1] == cur_cfg.gyro_id) begin
        res.status = imufd_pkg::ST_GYRO;
        scale = cur_cfg.gyro_scale;
      end else if (frame_buf[1] == cur_cfg.angle_id) begin
        res.status = imufd_pkg::ST_ANGLE;
        scale = cur_cfg.angle_scale;
      end
      if (res.status != imufd_pkg::ST_UNKNOWN) begin
        res.x = scale_word({frame_buf[3], frame_buf[2]}, scale);
        res.y = scale_word({frame_buf[5], frame_buf[4]}, scale);
        res.z = scale_word({frame_buf[7], frame_buf[6]}, scale);
      end
    end
    decoded_q.push_back(res);
    status_seen[int'(res.status)]++;
    in_frame = 1'b0;
    byte_cnt = 0;
    run_sum = '0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %08h, actual %08h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual status %0d data %024h",
               $time, m_axis_tuser, m_axis_tdata);
      n_errors++;
    end else begin
      want = decoded_q.pop_front();
      check_field("status", 32'(want.status), 32'(m_axis_tuser));
      check_field("axis_x", want.x, m_axis_tdata[31:0]);
      check_field("axis_y", want.y, m_axis_tdata[63:32]);
      check_field("axis_z", want.z, m_axis_tdata[95:64]);
    end
  endfunction

  // Byte driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_fire || !s_axis_tvalid) begin
        if (s_gap > 0) begin
          s_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          s_axis_tdata <= rx_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_gap = draw_wait(s_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result-side back pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_fire) m_stall = draw_wait(m_burst);
      if (m_stall > 0) begin
        m_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: mirrors every taken byte and checks every result word.
  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
    m_fire <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata);
        n_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               decoded_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_rx(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    n_pushed++;
    phase_bytes++;
  endtask

  task automatic push_frame(input logic [7:0] kind, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2, input bit bad);
    logic [7:0] fb [imufd_pkg::FRAME_LEN];
    logic [7:0] sum;
    fb[0] = cur_cfg.start_byte;
    fb[1] = kind;
    fb[2] = w0[7:0];
    fb[3] = w0[15:8];
    fb[4] = w1[7:0];
    fb[5] = w1[15:8];
    fb[6] = w2[7:0];
    fb[7] = w2[15:8];
    fb[8] = 8'($urandom);
    fb[9] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < SUM_LEN; i++) sum = sum + fb[i];
    fb[SUM_LEN] = bad ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < imufd_pkg::FRAME_LEN; i++) push_rx(fb[i]);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 3))
      0:       return cur_cfg.accel_id;
      1:       return cur_cfg.gyro_id;
      2:       return cur_cfg.angle_id;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic wait_bytes_taken();
    while (n_taken != n_pushed) @(negedge clk_i);
  endtask

  // Brings the block back to hunting with nothing in flight before registers change.
  task automatic settle();
    wait_bytes_taken();
    if (in_frame) begin
      repeat (imufd_pkg::FRAME_LEN - byte_cnt) push_rx(8'($urandom));
      wait_bytes_taken();
    end
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [imufd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [imufd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      imufd_pkg::REG_START_BYTE:  cur_cfg.start_byte = data[7:0];
      imufd_pkg::REG_ACCEL_ID:    cur_cfg.accel_id = data[7:0];
      imufd_pkg::REG_GYRO_ID:     cur_cfg.gyro_id = data[7:0];
      imufd_pkg::REG_ANGLE_ID:    cur_cfg.angle_id = data[7:0];
      imufd_pkg::REG_ACCEL_SCALE: cur_cfg.accel_scale = data;
      imufd_pkg::REG_GYRO_SCALE:  cur_cfg.gyro_scale = data;
      imufd_pkg::REG_ANGLE_SCALE: cur_cfg.angle_scale = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Byte registers get junk in the upper half of the write data, which must be dropped.
  task automatic program_all(input logic [7:0] start, input logic [7:0] acc_id,
                             input logic [7:0] gyr_id, input logic [7:0] ang_id,
                             input logic [15:0] acc_sc, input logic [15:0] gyr_sc,
                             input logic [15:0] ang_sc);
    write_reg(imufd_pkg::REG_START_BYTE, {8'($urandom), start});
    write_reg(imufd_pkg::REG_ACCEL_ID, {8'($urandom), acc_id});
    write_reg(imufd_pkg::REG_GYRO_ID, {8'($urandom), gyr_id});
    write_reg(imufd_pkg::REG_ANGLE_ID, {8'($urandom), ang_id});
    write_reg(imufd_pkg::REG_ACCEL_SCALE, acc_sc);
    write_reg(imufd_pkg::REG_GYRO_SCALE, gyr_sc);
    write_reg(imufd_pkg::REG_ANGLE_SCALE, ang_sc);
    write_reg(REG_NONE, 16'($urandom));
    n_settings++;
  endtask

  // Mostly whole frames; the rest are stray bytes and frames cut short.
  task automatic random_traffic();
    int pick;
    phase_bytes = 0;
    while (phase_bytes < PHASE_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        push_frame(pick_kind(), rand_word(), rand_word(), rand_word(),
                   $urandom_range(0, 9) == 0);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) push_rx(8'($urandom));
      end else begin
        push_rx(cur_cfg.start_byte);
        repeat ($urandom_range(1, 9)) push_rx(8'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    logic [7:0] shared_id;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Stray bytes while hunting, a frame of extreme words, then a bad checksum.
    push_rx(8'h00);
    push_rx(8'hFF);
    push_frame(imufd_pkg::RST_ACCEL_ID, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
    push_frame(imufd_pkg::RST_GYRO_ID, 16'h1234, 16'h0001, 16'hFEDC, 1'b1);
    settle();
    random_traffic();

    program_all(8'h00, 8'hFF, 8'h00, 8'h80, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_traffic();

    // All three ids equal, so every known frame must decode as acceleration.
    program_all(8'hFF, 8'h11, 8'h11, 8'h11, 16'h0000, 16'h0001, 16'h8000);
    random_traffic();

    // Rate and angle ids collide; rate must win.
    shared_id = 8'($urandom);
    program_all(8'($urandom), 8'($urandom), shared_id, shared_id, 16'($urandom),
                16'($urandom), 16'($urandom));
    random_traffic();

    repeat (2) begin
      program_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      random_traffic();
    end

    $display("Sent %0d bytes under %0d register settings.", n_pushed, n_settings);
    $display("Frames: accel %0d, gyro %0d, angle %0d, unknown kind %0d, bad checksum %0d.",
             status_seen[imufd_pkg::ST_ACCEL], status_seen[imufd_pkg::ST_GYRO],
             status_seen[imufd_pkg::ST_ANGLE], status_seen[imufd_pkg::ST_UNKNOWN],
             status_seen[imufd_pkg::ST_CSUM_ERR]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
